// ===== src/assert_macros.svh =====
// Assertion macros for the encoder RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ric_pkg.sv =====
// Package for the RV32IM instruction encoder: mnemonic codes, formats, error codes,
// opcode constants and the mnemonic lookup table. No dependencies.
package ric_pkg;

  // Widths of the fields
  localparam int unsigned KindW = 5;
  localparam int unsigned RegW  = 5;
  localparam int unsigned XlenW = 32;
  localparam int unsigned ErrW  = 2;
  localparam int unsigned FmtW  = 3;
  localparam int unsigned OpcW  = 7;
  localparam int unsigned F3W   = 3;
  localparam int unsigned F7W   = 7;

  // Mnemonic codes
  localparam logic [KindW-1:0] KIND_ADD     = 5'd0;
  localparam logic [KindW-1:0] KIND_AND     = 5'd1;
  localparam logic [KindW-1:0] KIND_OR      = 5'd2;
  localparam logic [KindW-1:0] KIND_SLL     = 5'd3;
  localparam logic [KindW-1:0] KIND_SLT     = 5'd4;
  localparam logic [KindW-1:0] KIND_SRA     = 5'd5;
  localparam logic [KindW-1:0] KIND_SRL     = 5'd6;
  localparam logic [KindW-1:0] KIND_SUB     = 5'd7;
  localparam logic [KindW-1:0] KIND_XOR     = 5'd8;
  localparam logic [KindW-1:0] KIND_MUL     = 5'd9;
  localparam logic [KindW-1:0] KIND_DIV     = 5'd10;
  localparam logic [KindW-1:0] KIND_REM     = 5'd11;
  localparam logic [KindW-1:0] KIND_ADDI    = 5'd12;
  localparam logic [KindW-1:0] KIND_ANDI    = 5'd13;
  localparam logic [KindW-1:0] KIND_ORI     = 5'd14;
  localparam logic [KindW-1:0] KIND_LB      = 5'd15;
  localparam logic [KindW-1:0] KIND_LD      = 5'd16;
  localparam logic [KindW-1:0] KIND_LH      = 5'd17;
  localparam logic [KindW-1:0] KIND_LW      = 5'd18;
  localparam logic [KindW-1:0] KIND_JALR    = 5'd19;
  localparam logic [KindW-1:0] KIND_SB      = 5'd20;
  localparam logic [KindW-1:0] KIND_SW      = 5'd21;
  localparam logic [KindW-1:0] KIND_SD      = 5'd22;
  localparam logic [KindW-1:0] KIND_SH      = 5'd23;
  localparam logic [KindW-1:0] KIND_BEQ     = 5'd24;
  localparam logic [KindW-1:0] KIND_BNE     = 5'd25;
  localparam logic [KindW-1:0] KIND_BGE     = 5'd26;
  localparam logic [KindW-1:0] KIND_BLT     = 5'd27;
  localparam logic [KindW-1:0] KIND_AUIPC   = 5'd28;
  localparam logic [KindW-1:0] KIND_LUI     = 5'd29;
  localparam logic [KindW-1:0] KIND_JAL     = 5'd30;
  localparam logic [KindW-1:0] KIND_UNKNOWN = 5'd31;

  // Instruction formats
  localparam logic [FmtW-1:0] FMT_R  = 3'd0;
  localparam logic [FmtW-1:0] FMT_I  = 3'd1;
  localparam logic [FmtW-1:0] FMT_S  = 3'd2;
  localparam logic [FmtW-1:0] FMT_SB = 3'd3;
  localparam logic [FmtW-1:0] FMT_U  = 3'd4;
  localparam logic [FmtW-1:0] FMT_UJ = 3'd5;

  // Error codes
  localparam logic [ErrW-1:0] ERR_OK    = 2'd0;
  localparam logic [ErrW-1:0] ERR_RANGE = 2'd1;
  localparam logic [ErrW-1:0] ERR_KIND  = 2'd2;

  // Major opcodes
  localparam logic [OpcW-1:0] OPC_OP     = 7'b0110011;
  localparam logic [OpcW-1:0] OPC_OP_IMM = 7'b0010011;
  localparam logic [OpcW-1:0] OPC_LOAD   = 7'b0000011;
  localparam logic [OpcW-1:0] OPC_JALR   = 7'b1100111;
  localparam logic [OpcW-1:0] OPC_STORE  = 7'b0100011;
  localparam logic [OpcW-1:0] OPC_BRANCH = 7'b1100011;
  localparam logic [OpcW-1:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [OpcW-1:0] OPC_LUI    = 7'b0110111;
  localparam logic [OpcW-1:0] OPC_JAL    = 7'b1101111;

  // funct7 values
  localparam logic [F7W-1:0] F7_BASE = 7'b0000000;
  localparam logic [F7W-1:0] F7_ALT  = 7'b0100000;
  localparam logic [F7W-1:0] F7_MULDIV = 7'b0000001;

  typedef struct packed {
    logic [FmtW-1:0] fmt;
    logic [OpcW-1:0] opc;
    logic [F3W-1:0]  f3;
    logic [F7W-1:0]  f7;
  } kind_desc_t;

  // Per-mnemonic format and fixed fields; unknown codes give an all-zero entry
  function automatic kind_desc_t kind_lookup(input logic [KindW-1:0] kind);
    kind_desc_t d;
    d = '{fmt: FMT_R, opc: '0, f3: '0, f7: '0};
    case (kind)
      KIND_ADD:   d = '{FMT_R,  OPC_OP,     3'd0, F7_BASE};
      KIND_AND:   d = '{FMT_R,  OPC_OP,     3'd7, F7_BASE};
      KIND_OR:    d = '{FMT_R,  OPC_OP,     3'd6, F7_BASE};
      KIND_SLL:   d = '{FMT_R,  OPC_OP,     3'd1, F7_BASE};
      KIND_SLT:   d = '{FMT_R,  OPC_OP,     3'd2, F7_BASE};
      KIND_SRA:   d = '{FMT_R,  OPC_OP,     3'd5, F7_ALT};
      KIND_SRL:   d = '{FMT_R,  OPC_OP,     3'd5, F7_BASE};
      KIND_SUB:   d = '{FMT_R,  OPC_OP,     3'd0, F7_ALT};
      KIND_XOR:   d = '{FMT_R,  OPC_OP,     3'd4, F7_BASE};
      KIND_MUL:   d = '{FMT_R,  OPC_OP,     3'd0, F7_MULDIV};
      KIND_DIV:   d = '{FMT_R,  OPC_OP,     3'd4, F7_MULDIV};
      KIND_REM:   d = '{FMT_R,  OPC_OP,     3'd6, F7_MULDIV};
      KIND_ADDI:  d = '{FMT_I,  OPC_OP_IMM, 3'd0, F7_BASE};
      KIND_ANDI:  d = '{FMT_I,  OPC_OP_IMM, 3'd7, F7_BASE};
      KIND_ORI:   d = '{FMT_I,  OPC_OP_IMM, 3'd6, F7_BASE};
      KIND_LB:    d = '{FMT_I,  OPC_LOAD,   3'd0, F7_BASE};
      KIND_LD:    d = '{FMT_I,  OPC_LOAD,   3'd3, F7_BASE};
      KIND_LH:    d = '{FMT_I,  OPC_LOAD,   3'd1, F7_BASE};
      KIND_LW:    d = '{FMT_I,  OPC_LOAD,   3'd2, F7_BASE};
      KIND_JALR:  d = '{FMT_I,  OPC_JALR,   3'd0, F7_BASE};
      KIND_SB:    d = '{FMT_S,  OPC_STORE,  3'd0, F7_BASE};
      KIND_SW:    d = '{FMT_S,  OPC_STORE,  3'd2, F7_BASE};
      KIND_SD:    d = '{FMT_S,  OPC_STORE,  3'd3, F7_BASE};
      KIND_SH:    d = '{FMT_S,  OPC_STORE,  3'd1, F7_BASE};
      KIND_BEQ:   d = '{FMT_SB, OPC_BRANCH, 3'd0, F7_BASE};
      KIND_BNE:   d = '{FMT_SB, OPC_BRANCH, 3'd1, F7_BASE};
      KIND_BGE:   d = '{FMT_SB, OPC_BRANCH, 3'd5, F7_BASE};
      KIND_BLT:   d = '{FMT_SB, OPC_BRANCH, 3'd4, F7_BASE};
      KIND_AUIPC: d = '{FMT_U,  OPC_AUIPC,  3'd0, F7_BASE};
      KIND_LUI:   d = '{FMT_U,  OPC_LUI,    3'd0, F7_BASE};
      KIND_JAL:   d = '{FMT_UJ, OPC_JAL,    3'd0, F7_BASE};
      default:    d = '{fmt: FMT_R, opc: '0, f3: '0, f7: '0};
    endcase
    return d;
  endfunction

endpackage

// ===== src/ric_encode.sv =====
// Combinational encoder: one decoded instruction in, machine word, error and format out.
// Depends on ric_pkg.
module ric_encode (
  input  logic [ric_pkg::KindW-1:0]  kind,
  input  logic [ric_pkg::RegW-1:0]   dest_reg,
  input  logic [ric_pkg::RegW-1:0]   src_reg_a,
  input  logic [ric_pkg::RegW-1:0]   src_reg_b,
  input  logic [ric_pkg::XlenW-1:0]  immediate,
  input  logic [ric_pkg::XlenW-1:0]  pc,
  input  logic [ric_pkg::XlenW-1:0]  target_address,
  output logic [ric_pkg::XlenW-1:0]  machine_word,
  output logic [ric_pkg::ErrW-1:0]   error,
  output logic [ric_pkg::FmtW-1:0]   format
);

  ric_pkg::kind_desc_t        desc;
  logic [ric_pkg::XlenW-1:0]  off;
  logic                       imm12_ok;
  logic                       off13_ok;
  logic                       imm20u_ok;
  logic [ric_pkg::XlenW-1:0]  word;
  logic [ric_pkg::ErrW-1:0]   err;

  assign desc = ric_pkg::kind_lookup(kind);
  assign off  = target_address - pc;

  // Range checks: upper bits must be a pure sign extension (or zero for U)
  assign imm12_ok  = (&immediate[31:11]) | ~(|immediate[31:11]);
  assign off13_ok  = (&off[31:12]) | ~(|off[31:12]);
  assign imm20u_ok = ~(|immediate[31:20]);

  // Field placement per format
  always_comb begin
    word = '0;
    err  = ric_pkg::ERR_OK;
    case (desc.fmt)
      ric_pkg::FMT_R: begin
        word = {desc.f7, src_reg_b, src_reg_a, desc.f3, dest_reg, desc.opc};
      end
      ric_pkg::FMT_I: begin
        if (!imm12_ok) err = ric_pkg::ERR_RANGE;
        word = {immediate[11:0], src_reg_a, desc.f3, dest_reg, desc.opc};
      end
      ric_pkg::FMT_S: begin
        if (!imm12_ok) err = ric_pkg::ERR_RANGE;
        word = {immediate[11:5], dest_reg, src_reg_a, desc.f3, immediate[4:0], desc.opc};
      end
      ric_pkg::FMT_SB: begin
        if (!off13_ok) err = ric_pkg::ERR_RANGE;
        word = {off[12], off[10:5], src_reg_b, src_reg_a, desc.f3,
                off[4:1], off[11], desc.opc};
      end
      ric_pkg::FMT_U: begin
        if (!imm20u_ok) err = ric_pkg::ERR_RANGE;
        word = {immediate[19:0], dest_reg, desc.opc};
      end
      ric_pkg::FMT_UJ: begin
        // offset wraps to 21 bits, never flagged
        word = {off[20], off[10:1], off[11], off[19:12], dest_reg, desc.opc};
      end
      default: begin
        word = '0;
        err  = ric_pkg::ERR_KIND;
      end
    endcase
    if (kind == ric_pkg::KIND_UNKNOWN) err = ric_pkg::ERR_KIND;
  end

  assign error        = err;
  assign machine_word = (err == ric_pkg::ERR_OK) ? word : '0;
  assign format       = (kind == ric_pkg::KIND_UNKNOWN) ? ric_pkg::FMT_R : desc.fmt;

endmodule

// ===== src/riscv_instruction_encoder.sv =====
// Top level of the RV32IM instruction encoder: input register, encoder, result register.
// Depends on ric_pkg, ric_encode and assert_macros.svh.
//
//  channel | direction | payload                                         | handshake
//  in_     | input     | kind, dest_reg, src_reg_a, src_reg_b, imm, pc,   | in_valid/in_ready
//          |           | target_address                                  |
//  out_    | output    | machine_word, error, format                     | out_valid/out_ready
//
// One instruction per cycle sustained while out_ready stays high; a taken beat passes the input and result registers.
// The path between the input register and the result register is the kind lookup and the
// 32-bit target minus pc subtraction with its range check.
// rst_n (synchronous) empties both stages; payload registers are not reset.
// A stall on out_ready fills the input stage and then drops in_ready; no beat is lost.
`include "assert_macros.svh"

module riscv_instruction_encoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ric_pkg::KindW-1:0]   in_kind,
  input  logic [ric_pkg::RegW-1:0]    in_dest_reg,
  input  logic [ric_pkg::RegW-1:0]    in_src_reg_a,
  input  logic [ric_pkg::RegW-1:0]    in_src_reg_b,
  input  logic [ric_pkg::XlenW-1:0]   in_immediate,
  input  logic [ric_pkg::XlenW-1:0]   in_pc,
  input  logic [ric_pkg::XlenW-1:0]   in_target_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ric_pkg::XlenW-1:0]   out_machine_word,
  output logic [ric_pkg::ErrW-1:0]    out_error,
  output logic [ric_pkg::FmtW-1:0]    out_format
);

  // Input stage
  logic                       s1_valid_r, s1_valid_nxt;
  logic [ric_pkg::KindW-1:0]  kind_r;
  logic [ric_pkg::RegW-1:0]   dest_reg_r;
  logic [ric_pkg::RegW-1:0]   src_reg_a_r;
  logic [ric_pkg::RegW-1:0]   src_reg_b_r;
  logic [ric_pkg::XlenW-1:0]  immediate_r;
  logic [ric_pkg::XlenW-1:0]  pc_r;
  logic [ric_pkg::XlenW-1:0]  target_r;

  // Result stage
  logic                       s2_valid_r, s2_valid_nxt;
  logic [ric_pkg::XlenW-1:0]  word_r;
  logic [ric_pkg::ErrW-1:0]   error_r;
  logic [ric_pkg::FmtW-1:0]   format_r;

  logic [ric_pkg::XlenW-1:0]  enc_word;
  logic [ric_pkg::ErrW-1:0]   enc_error;
  logic [ric_pkg::FmtW-1:0]   enc_format;

  logic in_take;
  logic s2_load;

  // Handshake: result stage loads when empty or being drained
  assign s2_load  = s1_valid_r && (!s2_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s2_load;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_load) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (s2_load) begin
      s2_valid_nxt = 1'b1;
    end else if (out_ready) begin
      s2_valid_nxt = 1'b0;
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // Input payload capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_r      <= in_kind;
      dest_reg_r  <= in_dest_reg;
      src_reg_a_r <= in_src_reg_a;
      src_reg_b_r <= in_src_reg_b;
      immediate_r <= in_immediate;
      pc_r        <= in_pc;
      target_r    <= in_target_address;
    end
  end

  ric_encode u_encode (
    .kind           (kind_r),
    .dest_reg       (dest_reg_r),
    .src_reg_a      (src_reg_a_r),
    .src_reg_b      (src_reg_b_r),
    .immediate      (immediate_r),
    .pc             (pc_r),
    .target_address (target_r),
    .machine_word   (enc_word),
    .error          (enc_error),
    .format         (enc_format)
  );

  // Result capture
  always_ff @(posedge clk) begin
    if (s2_load) begin
      word_r   <= enc_word;
      error_r  <= enc_error;
      format_r <= enc_format;
    end
  end

  assign out_valid        = s2_valid_r;
  assign out_machine_word = word_r;
  assign out_error        = error_r;
  assign out_format       = format_r;

  // Checks
  `ASSERT_IMPL(a_err_word_zero, out_valid && (out_error != ric_pkg::ERR_OK),
               out_machine_word == '0, "machine word not zero on error")
  `ASSERT_IMPL(a_kind_fmt, out_valid && (out_error == ric_pkg::ERR_KIND),
               out_format == ric_pkg::FMT_R, "unknown kind must report format R")
  `ASSERT_NEXT(a_load_shows, s2_load, out_valid, "loaded result not presented")
  `ASSERT_NEXT(a_hold_s1, s1_valid_r && !s2_load, s1_valid_r, "pending beat dropped")

endmodule
